// ----- sv/apd_pkg.sv -----
package apd_pkg;

  localparam int FIELD_W          = 7;
  localparam int OP_W             = 2;
  localparam int MAX_VERTICES_DEF = 64;

  localparam logic [FIELD_W-1:0] VCOUNT_RESET = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_EDGE  = 2'd1,
    OP_SOLVE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [FIELD_W-1:0] source_vertex;
    logic [FIELD_W-1:0] target_vertex;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] distance;
    logic [FIELD_W-1:0] max_distance;
    logic               error;
  } out_item_t;

endpackage

// ----- sv/all_pairs_hop_distance_unit.sv -----
// All-pairs hop distance unit for an undirected, unweighted graph.
// The input channel (in_valid, in_stall, in_item) takes one command item at a time:
// clear the matrix, add an edge, solve the closure or read one entry. Every item
// gives exactly one result item on the output channel (out_valid, out_stall,
// out_item) carrying the entry read, the largest entry of the last solve and an
// error flag for a vertex outside 1..n. cfg_we/cfg_wdata set the vertex count n;
// the user must write n only while the block is idle; the block does not enforce
// this. n is capped at MAX_VERTICES. A new item is taken only once the last one
// is done. The result becomes valid in the same cycle that the next item can be
// taken. The distance matrix sits in one memory with a single write port, and the
// closure streams one entry a cycle through a read-relax-write pipeline, with a
// fetch of the pivot column entry before each row.
// in_stall is high while an item is being worked on. A finished result waits in
// an output register while the receiver stalls; the next item is taken meanwhile
// and its result waits until that register is free.
// Reset (rst_n, synchronous, active low) sets n to 64, the largest entry to 0 and
// empties the output register. The matrix holds nothing defined until a clear.
module all_pairs_hop_distance_unit #(
  parameter int MAX_VERTICES = apd_pkg::MAX_VERTICES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  apd_pkg::in_item_t                   in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output apd_pkg::out_item_t                  out_item,
  input  logic                                cfg_we,
  input  logic [apd_pkg::FIELD_W-1:0]         cfg_wdata
);

  localparam int VW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int EW    = $clog2(MAX_VERTICES + 2);
  localparam int WW    = (EW > apd_pkg::FIELD_W) ? EW + 1 : apd_pkg::FIELD_W + 1;
  localparam int AW    = 2 * VW;
  localparam int DEPTH = 1 << AW;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_EDGE1, S_EDGE2, S_RDA, S_RDW, S_ROWA, S_COL, S_DRAIN, S_DONE
  } state_t;

  state_t                      state_r;
  logic [apd_pkg::FIELD_W-1:0] vcount_r;
  logic [apd_pkg::FIELD_W-1:0] s_r, t_r;
  logic [EW-1:0]               largest_r, best_r, best_nxt;
  logic [EW-1:0]               dist_r, rk_r;
  logic                        err_r;
  logic [VW-1:0]               k_r, r_r, c_r;
  logic                        first_r;
  logic                        p_v_r, p_last_r;
  logic [AW-1:0]               p_addr_r;
  logic [EW-1:0]               rd_a_r, rd_b_r;
  logic                        out_valid_r;
  apd_pkg::out_item_t          out_item_r;

  logic [EW-1:0]               mem [DEPTH];

  logic [WW-1:0]               n_w, src_w, tgt_w;
  logic                        n_zero, ok_in;
  logic [EW-1:0]               unreach;
  logic [VW-1:0]               nm1, s_idx, t_idx;
  logic                        we;
  logic [AW-1:0]               waddr, ra, rb;
  logic [EW-1:0]               wdata, relaxed;
  logic [EW:0]                 via;

  function automatic logic [apd_pkg::FIELD_W-1:0] to_field(input logic [EW-1:0] v);
    logic [WW-1:0] w;
    w = WW'(v);
    return w[apd_pkg::FIELD_W-1:0];
  endfunction

  assign n_w     = (WW'(vcount_r) > WW'(MAX_VERTICES)) ? WW'(MAX_VERTICES) : WW'(vcount_r);
  assign n_zero  = (n_w == '0);
  assign unreach = EW'(n_w + WW'(1));
  assign nm1     = VW'(n_w - WW'(1));
  assign src_w   = WW'(in_item.source_vertex);
  assign tgt_w   = WW'(in_item.target_vertex);
  assign ok_in   = (src_w != '0) && (src_w <= n_w) && (tgt_w != '0) && (tgt_w <= n_w);
  assign s_idx   = VW'(WW'(s_r) - WW'(1));
  assign t_idx   = VW'(WW'(t_r) - WW'(1));

  // relax step of the closure
  assign via      = (EW+1)'(rk_r) + (EW+1)'(rd_a_r);
  assign relaxed  = ((EW+1)'(rd_b_r) > via) ? via[EW-1:0] : rd_b_r;
  assign best_nxt = (p_v_r && p_last_r && (relaxed > best_r)) ? relaxed : best_r;

  always_comb begin
    we    = 1'b0;
    waddr = {r_r, c_r};
    wdata = (r_r == c_r) ? '0 : unreach;
    ra    = {k_r, c_r};
    rb    = {r_r, c_r};
    case (state_r)
      S_CLEAR: begin
        we = 1'b1;
      end
      S_EDGE1: begin
        we    = 1'b1;
        waddr = {s_idx, t_idx};
        wdata = EW'(1);
      end
      S_EDGE2: begin
        we    = 1'b1;
        waddr = {t_idx, s_idx};
        wdata = EW'(1);
      end
      S_RDA: begin
        ra = {s_idx, t_idx};
      end
      S_ROWA: begin
        ra = {r_r, k_r};
      end
      default: begin
      end
    endcase
    if (p_v_r) begin
      we    = 1'b1;
      waddr = p_addr_r;
      wdata = relaxed;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_r <= mem[ra];
    rd_b_r <= mem[rb];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcount_r    <= apd_pkg::VCOUNT_RESET;
      largest_r   <= '0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
      p_v_r       <= 1'b0;
      first_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        vcount_r <= cfg_wdata;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      p_v_r   <= 1'b0;
      first_r <= 1'b0;
      best_r  <= best_nxt;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            s_r    <= in_item.source_vertex;
            t_r    <= in_item.target_vertex;
            dist_r <= '0;
            err_r  <= 1'b0;
            k_r    <= '0;
            r_r    <= '0;
            c_r    <= '0;
            case (in_item.op)
              apd_pkg::OP_CLEAR: begin
                state_r <= n_zero ? S_DONE : S_CLEAR;
              end
              apd_pkg::OP_EDGE: begin
                if (!ok_in) begin
                  err_r   <= 1'b1;
                  state_r <= S_DONE;
                end else if (in_item.source_vertex == in_item.target_vertex) begin
                  state_r <= S_DONE;
                end else begin
                  state_r <= S_EDGE1;
                end
              end
              apd_pkg::OP_SOLVE: begin
                best_r <= '0;
                if (n_zero) begin
                  largest_r <= '0;
                  state_r   <= S_DONE;
                end else begin
                  state_r <= S_ROWA;
                end
              end
              apd_pkg::OP_READ: begin
                if (!ok_in) begin
                  err_r   <= 1'b1;
                  state_r <= S_DONE;
                end else begin
                  state_r <= S_RDA;
                end
              end
              default: begin
                state_r <= S_DONE;
              end
            endcase
          end
        end
        S_CLEAR: begin
          if (c_r == nm1) begin
            c_r <= '0;
            if (r_r == nm1) begin
              state_r <= S_DONE;
            end else begin
              r_r <= r_r + VW'(1);
            end
          end else begin
            c_r <= c_r + VW'(1);
          end
        end
        S_EDGE1: begin
          state_r <= S_EDGE2;
        end
        S_EDGE2: begin
          state_r <= S_DONE;
        end
        S_RDA: begin
          state_r <= S_RDW;
        end
        S_RDW: begin
          dist_r  <= rd_a_r;
          state_r <= S_DONE;
        end
        S_ROWA: begin
          first_r <= 1'b1;
          state_r <= S_COL;
        end
        S_COL: begin
          if (first_r) begin
            rk_r <= rd_a_r;
          end
          p_v_r    <= 1'b1;
          p_addr_r <= {r_r, c_r};
          p_last_r <= (k_r == nm1);
          if (c_r == nm1) begin
            c_r <= '0;
            if (r_r == nm1) begin
              r_r <= '0;
              if (k_r == nm1) begin
                state_r <= S_DRAIN;
              end else begin
                k_r     <= k_r + VW'(1);
                state_r <= S_ROWA;
              end
            end else begin
              r_r     <= r_r + VW'(1);
              state_r <= S_ROWA;
            end
          end else begin
            c_r <= c_r + VW'(1);
          end
        end
        S_DRAIN: begin
          largest_r <= best_nxt;
          state_r   <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r             <= 1'b1;
            out_item_r.distance     <= to_field(dist_r);
            out_item_r.max_distance <= to_field(largest_r);
            out_item_r.error        <= err_r;
            state_r                 <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_relax_in_solve: assert property (@(posedge clk) disable iff (!rst_n)
    p_v_r |-> (state_r == S_ROWA || state_r == S_COL || state_r == S_DRAIN))
    else $error("relax write outside solve");

  a_first_col_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COL && first_r) |-> !p_v_r)
    else $error("relax write overlaps pivot fetch");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !(out_valid_r && out_stall)) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not loaded");

  a_error_no_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.error) |-> (out_item_r.distance == '0))
    else $error("distance with error");

endmodule

// ----- test/all_pairs_hop_distance_unit_tb.sv -----
module all_pairs_hop_distance_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXV           = apd_pkg::MAX_VERTICES_DEF;
  localparam int SOLVE_MAX_N    = 16;
  localparam int LONG_HOLD      = 5000;
  localparam int WATCHDOG_LIMIT = 1_000_000;
  localparam int RANDOM_PHASES  = 24;
  localparam int PHASE_ITEMS    = 23;

  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        in_valid  = 1'b0;
  logic                        in_stall;
  apd_pkg::in_item_t           in_item   = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  apd_pkg::out_item_t          out_item;
  logic                        cfg_we    = 1'b0;
  logic [apd_pkg::FIELD_W-1:0] cfg_wdata = '0;

  apd_pkg::in_item_t  pending_cmds[$];
  apd_pkg::out_item_t hop_results_due[$];

  int hop_mat [MAXV][MAXV];
  int largest_hop    = 0;
  int vcount_model   = int'(apd_pkg::VCOUNT_RESET);
  int send_idle_pct  = 11;
  int recv_idle_pct  = 49;
  int items_queued   = 0;
  int items_taken    = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int idle_cycles    = 0;
  int mismatches     = 0;

  all_pairs_hop_distance_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic apd_pkg::out_item_t predict_hop(apd_pkg::in_item_t cmd);
    apd_pkg::out_item_t res;
    int n, s, t, via, best, r, c, k;
    bit ok;
    n = (vcount_model > MAXV) ? MAXV : vcount_model;
    s = cmd.source_vertex;
    t = cmd.target_vertex;
    ok = (s >= 1) && (s <= n) && (t >= 1) && (t <= n);
    res = '0;
    case (cmd.op)
      apd_pkg::OP_CLEAR: begin
        for (r = 0; r < n; r++)
          for (c = 0; c < n; c++)
            hop_mat[r][c] = (r == c) ? 0 : n + 1;
      end
      apd_pkg::OP_EDGE: begin
        if (!ok) begin
          res.error = 1'b1;
        end else if (s != t) begin
          hop_mat[s-1][t-1] = 1;
          hop_mat[t-1][s-1] = 1;
        end
      end
      apd_pkg::OP_SOLVE: begin
        best = 0;
        for (k = 0; k < n; k++)
          for (r = 0; r < n; r++)
            for (c = 0; c < n; c++) begin
              via = hop_mat[r][k] + hop_mat[k][c];
              if (hop_mat[r][c] > via) hop_mat[r][c] = via;
            end
        for (r = 0; r < n; r++)
          for (c = 0; c < n; c++)
            if (hop_mat[r][c] > best) best = hop_mat[r][c];
        largest_hop = best;
      end
      default: begin
        if (!ok) res.error = 1'b1;
        else res.distance = apd_pkg::FIELD_W'(hop_mat[s-1][t-1]);
      end
    endcase
    res.max_distance = apd_pkg::FIELD_W'(largest_hop);
    return res;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        hop_results_due.push_back(predict_hop(in_item));
        items_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item  <= pending_cmds.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    apd_pkg::out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (hop_results_due.size() == 0) begin
          $error("result item with nothing expected: %p", out_item);
          mismatches++;
        end else begin
          want = hop_results_due.pop_front();
          if (out_item.distance !== want.distance) begin
            $error("distance: expected %0d, got %0d", want.distance, out_item.distance);
            mismatches++;
          end
          if (out_item.max_distance !== want.max_distance) begin
            $error("max_distance: expected %0d, got %0d", want.max_distance,
                   out_item.max_distance);
            mismatches++;
          end
          if (out_item.error !== want.error) begin
            $error("error: expected %0d, got %0d", want.error, out_item.error);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (hold_served != hold_requests) begin
        hold_served <= hold_served + 1;
        hold_left   <= LONG_HOLD;
        out_stall   <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_cmd(apd_pkg::op_t op, int s, int t);
    apd_pkg::in_item_t cmd;
    cmd.op            = op;
    cmd.source_vertex = apd_pkg::FIELD_W'(s);
    cmd.target_vertex = apd_pkg::FIELD_W'(t);
    pending_cmds.push_back(cmd);
    items_queued++;
  endtask

  task automatic settle();
    while (items_taken != items_queued || hop_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_vcount(int v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= apd_pkg::FIELD_W'(v);
    @(posedge clk);
    cfg_we       <= 1'b0;
    vcount_model = v;
  endtask

  function automatic int pick_vertex(int n);
    if (n == 0) return $urandom_range(0, 127);
    if ($urandom_range(99) < 8) begin
      if ($urandom_range(1)) return 0;
      return $urandom_range(n + 1, 127);
    end
    return $urandom_range(1, n);
  endfunction

  initial begin
    int p, i, vc, n, sel;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default count of 64
    queue_cmd(apd_pkg::OP_CLEAR, 0, 0);
    queue_cmd(apd_pkg::OP_EDGE, 1, 64);
    queue_cmd(apd_pkg::OP_EDGE, 5, 5);
    queue_cmd(apd_pkg::OP_READ, 5, 5);
    queue_cmd(apd_pkg::OP_READ, 64, 1);
    queue_cmd(apd_pkg::OP_READ, 2, 3);
    queue_cmd(apd_pkg::OP_EDGE, 0, 3);
    queue_cmd(apd_pkg::OP_READ, 65, 1);
    queue_cmd(apd_pkg::OP_EDGE, 127, 127);
    queue_cmd(apd_pkg::OP_READ, 64, 64);

    // count above capacity, one full-size solve
    write_vcount(127);
    queue_cmd(apd_pkg::OP_CLEAR, 127, 127);
    queue_cmd(apd_pkg::OP_EDGE, 1, 2);
    queue_cmd(apd_pkg::OP_EDGE, 2, 3);
    queue_cmd(apd_pkg::OP_SOLVE, 0, 0);
    queue_cmd(apd_pkg::OP_READ, 1, 3);
    queue_cmd(apd_pkg::OP_READ, 1, 64);

    // no vertices
    write_vcount(0);
    queue_cmd(apd_pkg::OP_CLEAR, 0, 0);
    queue_cmd(apd_pkg::OP_EDGE, 1, 1);
    queue_cmd(apd_pkg::OP_READ, 1, 1);
    queue_cmd(apd_pkg::OP_SOLVE, 0, 0);

    // single vertex
    write_vcount(1);
    queue_cmd(apd_pkg::OP_CLEAR, 1, 1);
    queue_cmd(apd_pkg::OP_EDGE, 1, 1);
    queue_cmd(apd_pkg::OP_SOLVE, 0, 0);
    queue_cmd(apd_pkg::OP_READ, 1, 1);
    queue_cmd(apd_pkg::OP_EDGE, 1, 2);

    for (p = 0; p < RANDOM_PHASES; p++) begin
      sel = $urandom_range(99);
      if (sel < 70) vc = $urandom_range(2, 8);
      else if (sel < 85) vc = $urandom_range(9, SOLVE_MAX_N);
      else if (sel < 90) vc = $urandom_range(0, 1);
      else vc = $urandom_range(SOLVE_MAX_N + 1, 127);
      write_vcount(vc);
      n = (vc > MAXV) ? MAXV : vc;
      if (p == 8) begin
        send_idle_pct = 49;
        recv_idle_pct = 11;
      end
      if (p == 16) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 3 || p == 18) hold_requests++;
      queue_cmd(apd_pkg::OP_CLEAR, $urandom_range(0, 127), $urandom_range(0, 127));
      for (i = 1; i < PHASE_ITEMS; i++) begin
        sel = $urandom_range(99);
        if (sel < 45) queue_cmd(apd_pkg::OP_EDGE, pick_vertex(n), pick_vertex(n));
        else if (sel < 78 || (sel < 92 && n > SOLVE_MAX_N))
          queue_cmd(apd_pkg::OP_READ, pick_vertex(n), pick_vertex(n));
        else if (sel < 92)
          queue_cmd(apd_pkg::OP_SOLVE, $urandom_range(0, 127), $urandom_range(0, 127));
        else queue_cmd(apd_pkg::OP_CLEAR, $urandom_range(0, 127), $urandom_range(0, 127));
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && hop_results_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
